@@ src/olvs_pkg.sv @@
package olvs_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_VALUE_BITS = 32;

    localparam int KIND_W   = 2;
    localparam int DATA_W   = 32;
    localparam int RUN_W    = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND    = 2'd0,
        KIND_REMOVE    = 2'd1,
        KIND_READ_FROM = 2'd2,
        KIND_READ_ALL  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_SEARCH,
        ST_EMIT,
        ST_RESTORE
    } state_t;

    // Command shared by every cell of the chain.
    typedef struct packed {
        logic shift;   // every cell takes its right neighbor; the last cell keeps its own
        logic wr_en;   // the cell at wr_pos takes wr_data instead
    } cell_cmd_t;

endpackage

@@ src/olvs_cell.sv @@
module olvs_cell #(
    parameter int VALUE_BITS = olvs_pkg::DEF_VALUE_BITS,
    parameter int POS_BITS   = 4,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  olvs_pkg::cell_cmd_t   cmd,
    input  logic [POS_BITS-1:0]   wr_pos,
    input  logic [VALUE_BITS-1:0] wr_data,
    input  logic [VALUE_BITS-1:0] nbr,
    output logic [VALUE_BITS-1:0] val
);
    import olvs_pkg::*;

    logic                  here;
    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] val_next;

    assign here = cmd.wr_en && (wr_pos == POS_BITS'(INDEX));

    always_comb
    begin
        val_next = val_reg;
        if (here)
        begin
            val_next = wr_data;
        end
        else if (cmd.shift)
        begin
            val_next = nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

@@ src/olvs_ctrl.sv @@
module olvs_ctrl #(
    parameter int CAPACITY   = olvs_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = olvs_pkg::DEF_VALUE_BITS,
    parameter int POS_BITS   = $clog2(CAPACITY)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [olvs_pkg::KIND_W-1:0]    kind,
    input  logic [olvs_pkg::DATA_W-1:0]    value,
    input  logic [olvs_pkg::RUN_W-1:0]     run_length,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [olvs_pkg::DATA_W-1:0]    entry,
    output logic                           has_entry,
    output logic                           last,
    output logic [olvs_pkg::STATUS_W-1:0]  status,
    output logic [olvs_pkg::COUNT_W-1:0]   count,
    input  logic [VALUE_BITS-1:0]          head,
    output olvs_pkg::cell_cmd_t            cmd,
    output logic [POS_BITS-1:0]            wr_pos,
    output logic [VALUE_BITS-1:0]          wr_data
);
    import olvs_pkg::*;

    localparam int FW = $clog2(CAPACITY + 1);
    localparam int RW = (FW > RUN_W) ? FW : RUN_W;

    state_t                 state_reg, state_next;
    logic [FW-1:0]          fill_reg, fill_next;
    logic [VALUE_BITS-1:0]  key_reg, key_next;
    logic [RUN_W-1:0]       run_reg, run_next;
    logic [FW-1:0]          step_reg, step_next;
    logic [FW-1:0]          len_reg, len_next;
    logic [POS_BITS-1:0]    rot_reg, rot_next;
    logic [FW-1:0]          left_reg, left_next;

    logic                   out_valid_reg;
    logic [DATA_W-1:0]      entry_reg, entry_next;
    logic                   has_reg, has_next;
    logic                   last_reg, last_next;
    status_t                status_reg, status_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   ld;

    logic                   slot_free;
    logic                   accept;
    logic                   match;
    logic                   last_step;
    logic                   run_short;
    logic [FW-1:0]          fill_m1;
    logic [FW-1:0]          len_after;
    logic [POS_BITS-1:0]    rot_inc;
    kind_t                  kind_in;

    assign slot_free = !out_valid_reg || out_ready;
    assign kind_in   = kind_t'(kind);
    assign accept    = in_valid && in_ready;
    assign match     = (head == key_reg);
    assign fill_m1   = fill_reg - FW'(1);
    assign last_step = (step_reg == fill_m1);
    assign run_short = (RW'(run_reg) < RW'(fill_reg));
    assign len_after = match ? (len_reg - FW'(1)) : len_reg;
    assign rot_inc   = (FW'(rot_reg) == fill_m1) ? '0 : (rot_reg + POS_BITS'(1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && fill_reg != '0)
                begin
                    unique case (kind_in)
                        KIND_REMOVE:    state_next = ST_REMOVE;
                        KIND_READ_FROM: state_next = ST_SEARCH;
                        KIND_READ_ALL:  state_next = ST_EMIT;
                        default:        state_next = ST_IDLE;
                    endcase
                end
            end
            ST_REMOVE:
            begin
                if (last_step && slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                if (match)
                begin
                    if (run_reg != '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (slot_free)
                    begin
                        state_next = ST_RESTORE;
                    end
                end
                else if (last_step && slot_free)
                begin
                    state_next = ST_RESTORE;
                end
            end
            ST_EMIT:
            begin
                if (slot_free && left_reg == FW'(1))
                begin
                    state_next = ST_RESTORE;
                end
            end
            ST_RESTORE:
            begin
                if (rot_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        wr_pos      = POS_BITS'(fill_m1);
        wr_data     = head;
        ld          = 1'b0;
        entry_next  = '0;
        has_next    = 1'b0;
        last_next   = 1'b1;
        status_next = STAT_OK;
        count_next  = COUNT_W'(fill_reg);
        fill_next   = fill_reg;
        key_next    = key_reg;
        run_next    = run_reg;
        step_next   = step_reg;
        len_next    = len_reg;
        rot_next    = rot_reg;
        left_next   = left_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = slot_free;
                if (accept)
                begin
                    key_next  = VALUE_BITS'(value);
                    run_next  = run_length;
                    step_next = '0;
                    len_next  = fill_reg;
                    rot_next  = '0;
                    left_next = fill_reg;
                    if (kind_in == KIND_APPEND)
                    begin
                        ld = 1'b1;
                        if (fill_reg == FW'(CAPACITY))
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            cmd.wr_en  = 1'b1;
                            wr_pos     = POS_BITS'(fill_reg);
                            wr_data    = VALUE_BITS'(value);
                            fill_next  = fill_reg + FW'(1);
                            count_next = COUNT_W'(fill_reg + FW'(1));
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        ld          = 1'b1;
                        status_next = STAT_EMPTY;
                    end
                end
            end
            ST_REMOVE:
            begin
                // Pop the head; a kept value goes back in at the tail of the
                // shrinking window, a matching one is simply dropped.
                if (!last_step || slot_free)
                begin
                    cmd.shift = 1'b1;
                    cmd.wr_en = !match;
                    wr_pos    = POS_BITS'(len_reg - FW'(1));
                    len_next  = len_after;
                    step_next = step_reg + FW'(1);
                    if (last_step)
                    begin
                        ld         = 1'b1;
                        count_next = COUNT_W'(len_after);
                        fill_next  = len_after;
                        if (len_after == fill_reg)
                        begin
                            status_next = STAT_NOT_FOUND;
                        end
                    end
                end
            end
            ST_SEARCH:
            begin
                if (match)
                begin
                    left_next = run_short ? FW'(run_reg) : fill_reg;
                    if (run_reg == '0 && slot_free)
                    begin
                        ld = 1'b1;
                    end
                end
                else if (!last_step || slot_free)
                begin
                    cmd.shift = 1'b1;
                    cmd.wr_en = 1'b1;
                    rot_next  = rot_inc;
                    step_next = step_reg + FW'(1);
                    if (last_step)
                    begin
                        ld          = 1'b1;
                        status_next = STAT_NOT_FOUND;
                    end
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ld         = 1'b1;
                    entry_next = DATA_W'(head);
                    has_next   = 1'b1;
                    last_next  = (left_reg == FW'(1));
                    cmd.shift  = 1'b1;
                    cmd.wr_en  = 1'b1;
                    rot_next   = rot_inc;
                    left_next  = left_reg - FW'(1);
                end
            end
            ST_RESTORE:
            begin
                // Keep turning the ring until the head is back at cell zero.
                if (rot_reg != '0)
                begin
                    cmd.shift = 1'b1;
                    cmd.wr_en = 1'b1;
                    rot_next  = rot_inc;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        run_reg  <= run_next;
        step_reg <= step_next;
        len_reg  <= len_next;
        rot_reg  <= rot_next;
        left_reg <= left_next;
        if (ld)
        begin
            entry_reg  <= entry_next;
            has_reg    <= has_next;
            last_reg   <= last_next;
            status_reg <= status_next;
            count_reg  <= count_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign entry     = entry_reg;
    assign has_entry = has_reg;
    assign last      = last_reg;
    assign status    = status_reg;
    assign count     = count_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_fill_change: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_next != fill_reg) |-> (state_reg == ST_IDLE || state_reg == ST_REMOVE))
        else $error("entry count changed during a read");

    a_emit_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (left_reg != '0))
        else $error("read-out with nothing left to send");

    a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESTORE) |-> (FW'(rot_reg) < fill_reg))
        else $error("ring offset outside the list");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ld |-> slot_free)
        else $error("result overwrote a beat not yet taken");

endmodule

@@ src/ordered_value_list_store.sv @@
// Append writes the value at the tail; remove walks the list once, one entry per cycle,
// the last entry waiting for a free output slot. A read turns the ring of cells one place
// per entry skipped or sent, then keeps turning until the head is back in cell zero.
// One operation is in flight at a time; the output register lets the last beat wait.
// Reset (rst_n low, asynchronous) empties the list, returns the controller to idle and
// clears out_valid; the entry cells themselves are not cleared.
module ordered_value_list_store #(
    parameter int CAPACITY   = olvs_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = olvs_pkg::DEF_VALUE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [olvs_pkg::KIND_W-1:0]    kind,
    input  logic [olvs_pkg::DATA_W-1:0]    value,
    input  logic [olvs_pkg::RUN_W-1:0]     run_length,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [olvs_pkg::DATA_W-1:0]    entry,
    output logic                           has_entry,
    output logic                           last,
    output logic [olvs_pkg::STATUS_W-1:0]  status,
    output logic [olvs_pkg::COUNT_W-1:0]   count
);
    import olvs_pkg::*;

    localparam int PW = $clog2(CAPACITY);

    logic [VALUE_BITS-1:0] cell_val [CAPACITY];
    cell_cmd_t             cmd;
    logic [PW-1:0]         wr_pos;
    logic [VALUE_BITS-1:0] wr_data;

    olvs_ctrl #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .POS_BITS   (PW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .value      (value),
        .run_length (run_length),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .entry      (entry),
        .has_entry  (has_entry),
        .last       (last),
        .status     (status),
        .count      (count),
        .head       (cell_val[0]),
        .cmd        (cmd),
        .wr_pos     (wr_pos),
        .wr_data    (wr_data)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        olvs_cell #(
            .VALUE_BITS (VALUE_BITS),
            .POS_BITS   (PW),
            .INDEX      (i)
        ) u_cell (
            .clk     (clk),
            .cmd     (cmd),
            .wr_pos  (wr_pos),
            .wr_data (wr_data),
            .nbr     (cell_val[(i + 1 < CAPACITY) ? i + 1 : i]),
            .val     (cell_val[i])
        );
    end

endmodule
